FILE: hdl/sdfs_pkg.sv
// Shared constants for the first-seen duplicate filter.
// Depends on nothing; read by the interfaces and the top level.
package sdfs_pkg;

	// Default store depth and value width.
	localparam int STORE_DEPTH_DEF = 64;
	localparam int VALUE_WIDTH_DEF = 16;

	// Width of a count that can hold 0 through STORE_DEPTH_DEF.
	localparam int COUNT_WIDTH_DEF = $clog2(STORE_DEPTH_DEF + 1);

endpackage

FILE: hdl/sdfs_if.sv
// Valid/ready stream interfaces for the input and result channels.
// Depends on sdfs_pkg for default widths.

// Input request: one value of the run and its end-of-run mark.
interface sdfs_in_if #(
	parameter int VALUE_WIDTH = sdfs_pkg::VALUE_WIDTH_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;
	logic                   last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

// Result request: the echoed value, its classification and the count.
interface sdfs_out_if #(
	parameter int VALUE_WIDTH = sdfs_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = sdfs_pkg::COUNT_WIDTH_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value_out;
	logic                   first_seen;
	logic [COUNT_WIDTH-1:0] distinct_count;
	logic                   overflow;
	logic                   last_out;

	modport source (output valid, output value_out, output first_seen,
		output distinct_count, output overflow, output last_out, input ready);
	modport sink (input valid, input value_out, input first_seen,
		input distinct_count, input overflow, input last_out, output ready);
endinterface

FILE: hdl/sdfs_store.sv
// Distinct-value store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module sdfs_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_WIDTH-1:0] wr_addr,
	input  logic [WIDTH-1:0]      wr_data,
	input  logic                  rd_en,
	input  logic [ADDR_WIDTH-1:0] rd_addr,
	output logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/stream_dedup_first_seen.sv
// Top level of the first-seen duplicate filter: sequencer, count and result register.
// Depends on sdfs_pkg, the interfaces in sdfs_if and the store in sdfs_store.
//
//   channel   direction  payload                                                 handshake
//   in_ch     in         value, last                                             valid/ready
//   out_ch    out        value_out, first_seen, distinct_count, overflow,        valid/ready
//                        last_out
//
// Items are taken one at a time: a request is accepted in idle, the scan reads the N distinct
// values held in the current run (N up to STORE_DEPTH, none with an empty store) through
// the single read port and compares each with the item, the scan closes, and the item
// completes and the sequencer returns to idle. A match on a held entry ends the scan early.
// Reset clears the count, the sequencer and the result register; the store holds
// no reset value and needs no clearing pass, since only entries written earlier in
// the run are read. A stalled result stays in the output register while the next
// item is scanned; that item completes once the register is free.
module stream_dedup_first_seen #(
	parameter int STORE_DEPTH = sdfs_pkg::STORE_DEPTH_DEF,
	parameter int VALUE_WIDTH = sdfs_pkg::VALUE_WIDTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	sdfs_in_if.sink    in_ch,
	sdfs_out_if.source out_ch
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(STORE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic                   last_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          issue_q;
	logic                   rd_vld_s1;
	logic                   found_q;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_first_q;
	logic [CW-1:0]          out_count_q;
	logic                   out_ovf_q;
	logic                   out_last_q;

	logic                   rd_en;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   match;
	logic                   scan_end;
	logic                   slot_free;
	logic                   finish;
	logic                   is_full;
	logic                   wr_en;

	// Scan control: one read per cycle until every held entry is issued or a hit.
	assign match     = (state_q == ST_SCAN) && rd_vld_s1 && (rd_data == val_q);
	assign rd_en     = (state_q == ST_SCAN) && (issue_q < cnt_q) && !match;
	assign scan_end  = (state_q == ST_SCAN) && (match || ((issue_q == cnt_q) && !rd_vld_s1));

	// Completion: the result register must be empty or emptying.
	assign slot_free = !out_valid_q || out_ch.ready;
	assign finish    = (state_q == ST_DONE) && slot_free;
	assign is_full   = (cnt_q == FULL_COUNT);
	assign wr_en     = finish && !found_q && !is_full;

	assign in_ch.ready = (state_q == ST_IDLE);

	sdfs_store #(
		.DEPTH      (STORE_DEPTH),
		.WIDTH      (VALUE_WIDTH),
		.ADDR_WIDTH (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (val_q),
		.rd_en   (rd_en),
		.rd_addr (issue_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Sequencer, running count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			val_q       <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_first_q <= 1'b0;
			out_count_q <= '0;
			out_ovf_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;

			// Result is loaded on completion and leaves when taken downstream.
			out_valid_q <= finish || (out_valid_q && !out_ch.ready);

			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						val_q   <= in_ch.value;
						last_q  <= in_ch.last;
						issue_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (scan_end) begin
						found_q <= match;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						out_value_q <= val_q;
						out_first_q <= wr_en;
						out_ovf_q   <= !found_q && is_full;
						out_last_q  <= last_q;
						out_count_q <= wr_en ? cnt_q + 1'b1 : cnt_q;
						// The run ends after its last item.
						if (last_q) begin
							cnt_q <= '0;
						end else if (wr_en) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.value_out      = out_value_q;
	assign out_ch.first_seen     = out_first_q;
	assign out_ch.distinct_count = out_count_q;
	assign out_ch.overflow       = out_ovf_q;
	assign out_ch.last_out       = out_last_q;

endmodule
